FILE: hdl/bbf_pkg.sv
package bbf_pkg;

    localparam int DEPTH     = 4096;
    localparam int MAX_BYTES = 8;
    localparam int AW        = $clog2(DEPTH);
    localparam int POS_W     = 13;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 64;

    localparam logic       KIND_WRITE    = 1'b0;
    localparam logic       KIND_READ     = 1'b1;
    localparam logic [POS_W-1:0] CAP_RESET = POS_W'(4096);

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic              kind;
        logic              probe_only;
        logic [CNT_W-1:0]  length;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  granted;
        logic [DATA_W-1:0] read_data;
    } rsp_t;

    // Byte counts and region pointer updates worked out before the byte loop.
    typedef struct packed {
        cnt_t cnt1;
        cnt_t cnt2;
        cnt_t granted;
        pos_t base1;
        pos_t rp_next;
        pos_t a_end_next;
        pos_t b_end_next;
    } plan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_ACCESS,
        ST_DRAIN,
        ST_DONE
    } state_t;

    function automatic pos_t sat_sub(input pos_t a, input pos_t b);
        return (a > b) ? pos_t'(a - b) : '0;
    endfunction

endpackage

FILE: hdl/bbf_plan.sv
module bbf_plan (
    input  bbf_pkg::req_t  req,
    input  bbf_pkg::pos_t  read_pos,
    input  bbf_pkg::pos_t  a_end,
    input  bbf_pkg::pos_t  b_end,
    input  bbf_pkg::pos_t  cap_eff,
    output bbf_pkg::plan_t plan
);
    import bbf_pkg::*;

    cnt_t len;
    pos_t room;
    cnt_t room_cnt;
    cnt_t rest;

    always_comb
    begin
        len      = (req.length > cnt_t'(MAX_BYTES)) ? cnt_t'(MAX_BYTES) : req.length;
        room     = '0;
        room_cnt = '0;
        rest     = '0;

        plan.cnt1       = '0;
        plan.cnt2       = '0;
        plan.base1      = '0;
        plan.rp_next    = read_pos;
        plan.a_end_next = a_end;
        plan.b_end_next = b_end;

        if (req.kind == KIND_WRITE)
        begin
            if (b_end != '0)
            begin
                // Region B grows up to the read position.
                room       = sat_sub(read_pos, b_end);
                plan.cnt1  = (pos_t'(len) < room) ? len : cnt_t'(room);
                plan.base1 = b_end;
                plan.b_end_next = b_end + pos_t'(plan.cnt1);
            end
            else
            begin
                room = sat_sub(cap_eff, a_end);
                if (room > pos_t'(len))
                begin
                    plan.cnt1       = len;
                    plan.base1      = a_end;
                    plan.a_end_next = a_end + pos_t'(len);
                end
                else
                begin
                    // Fill the tail of A, then wrap into a new region B.
                    room_cnt   = cnt_t'(room);
                    rest       = len - room_cnt;
                    plan.cnt1  = room_cnt;
                    plan.cnt2  = (pos_t'(rest) > read_pos) ? cnt_t'(read_pos) : rest;
                    plan.base1 = a_end;
                    plan.a_end_next = (a_end < cap_eff) ? cap_eff : a_end;
                    plan.b_end_next = pos_t'(plan.cnt2);
                end
            end
        end
        else
        begin
            room = sat_sub(a_end, read_pos);
            plan.base1 = read_pos;
            if (room > pos_t'(len))
            begin
                plan.cnt1    = len;
                plan.rp_next = read_pos + pos_t'(len);
            end
            else
            begin
                // A is drained: B becomes the new A.
                room_cnt        = cnt_t'(room);
                rest            = len - room_cnt;
                plan.cnt1       = room_cnt;
                plan.cnt2       = (pos_t'(rest) > b_end) ? cnt_t'(b_end) : rest;
                plan.rp_next    = pos_t'(plan.cnt2);
                plan.a_end_next = b_end;
                plan.b_end_next = '0;
            end
        end

        plan.granted = plan.cnt1 + plan.cnt2;
    end

endmodule

FILE: hdl/bipartite_byte_fifo.sv
// Byte FIFO held as a bipartite buffer in one byte-wide 4096-entry memory.
// Each input beat is a write or a read of up to eight bytes; the result beat
// reports how many bytes were granted and, for reads, the bytes themselves.
// A shared sequencer plans the request, then touches the memory
// one byte per cycle through its single port; a new item is taken only
// after the last one has passed its plan, access, drain and done states
// (probes skip access). Input stall is high while an item is in progress. The
// result sits in an output register, so a new item can be taken while the
// previous result waits. Change capacity only while the store is empty.
module bipartite_byte_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bbf_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bbf_pkg::rsp_t                  out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbf_pkg::POS_W-1:0]      cfg_data
);
    import bbf_pkg::*;

    state_t state_reg, state_next;

    req_t  req_reg;
    plan_t plan_reg;
    plan_t plan;

    pos_t read_pos_reg, a_end_reg, b_end_reg, cap_reg;
    pos_t cap_eff;

    pos_t             addr_reg;
    cnt_t             rem_reg;
    cnt_t             seg1_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [7:0]       mem_q_reg;
    logic [DATA_W-1:0] acc_reg;

    logic out_valid_reg;
    rsp_t out_data_reg;

    logic [7:0] mem [DEPTH];

    logic accept;
    logic out_free;
    logic do_plan, do_step, do_update, do_load;
    logic addr_ok;
    logic wr_en;
    logic [7:0] wr_byte;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cap_eff  = (32'(cap_reg) > DEPTH) ? pos_t'(DEPTH) : cap_reg;
    assign addr_ok  = (32'(addr_reg) < DEPTH);
    assign wr_en    = do_step && (req_reg.kind == KIND_WRITE) && addr_ok;
    assign wr_byte  = req_reg.write_data[{idx_reg, 3'b000} +: 8];

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    bbf_plan u_plan (
        .req      (req_reg),
        .read_pos (read_pos_reg),
        .a_end    (a_end_reg),
        .b_end    (b_end_reg),
        .cap_eff  (cap_eff),
        .plan     (plan)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                if (req_reg.probe_only || plan.granted == '0)
                    state_next = ST_DRAIN;
                else
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (rem_reg == cnt_t'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        do_plan   = 1'b0;
        do_step   = 1'b0;
        do_update = 1'b0;
        do_load   = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall  = 1'b0;
            ST_PLAN:   do_plan   = 1'b1;
            ST_ACCESS: do_step   = 1'b1;
            ST_DRAIN:  do_update = !req_reg.probe_only;
            ST_DONE:   do_load   = out_free;
            default:   in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            read_pos_reg  <= '0;
            a_end_reg     <= '0;
            b_end_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rem_reg       <= '0;
            seg1_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;

            if (do_plan)
            begin
                rem_reg  <= plan.granted;
                seg1_reg <= plan.cnt1;
                idx_reg  <= '0;
            end
            else if (do_step)
            begin
                rem_reg  <= rem_reg - cnt_t'(1);
                idx_reg  <= idx_reg + IDX_W'(1);
                if (seg1_reg != '0)
                    seg1_reg <= seg1_reg - cnt_t'(1);
            end

            rd_pend_reg <= do_step && (req_reg.kind == KIND_READ) && addr_ok;

            if (do_update)
            begin
                read_pos_reg <= plan_reg.rp_next;
                a_end_reg    <= plan_reg.a_end_next;
                b_end_reg    <= plan_reg.b_end_next;
            end

            if (do_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;

        if (accept)
        begin
            req_reg <= in_data;
            acc_reg <= '0;
        end
        else if (rd_pend_reg)
            acc_reg[{rd_idx_reg, 3'b000} +: 8] <= mem_q_reg;

        if (do_plan)
        begin
            plan_reg <= plan;
            addr_reg <= (plan.cnt1 == '0) ? '0 : plan.base1;
        end
        else if (do_step)
        begin
            // The first segment ends at the region edge; the second starts at 0.
            if (seg1_reg == cnt_t'(1))
                addr_reg <= '0;
            else
                addr_reg <= addr_reg + pos_t'(1);
        end

        if (do_load)
        begin
            out_data_reg.granted   <= plan_reg.granted;
            out_data_reg.read_data <= acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(addr_reg)] <= wr_byte;
        mem_q_reg <= mem[AW'(addr_reg)];
    end

endmodule
